FILE: hw/rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

    typedef logic [15:0] t_cell;
    typedef logic [7:0]  t_byte;

    localparam t_byte NEWLINE_CODE = 8'h0A;
    localparam t_byte SPACE_CODE   = 8'h20;
    localparam t_byte RESET_COLOR  = 8'h07;
    localparam t_cell BLANK_CELL   = {RESET_COLOR, SPACE_CODE};

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam int CURSOR_POS_W = 11;
    localparam int CELL_ADDR_W  = 11;

endpackage

FILE: hw/rtl/tcw_in_if.sv
// Input item channel of the text console writer.
interface tcw_in_if
    import tcw_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   op;
    t_byte                  char_code;
    logic [CELL_ADDR_W-1:0] cell_address;

    modport source (output valid, output op, output char_code, output cell_address,
                    input ready);
    modport sink   (input valid, input op, input char_code, input cell_address,
                    output ready);
endinterface

FILE: hw/rtl/tcw_out_if.sv
// Result item channel of the text console writer.
interface tcw_out_if
    import tcw_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CURSOR_POS_W-1:0] cursor_pos;
    t_cell                   cell_data;
    logic                    scrolled;

    modport source (output valid, output cursor_pos, output cell_data, output scrolled,
                    input ready);
    modport sink   (input valid, input cursor_pos, input cell_data, input scrolled,
                    output ready);
endinterface

FILE: hw/rtl/tcw_cfg_if.sv
// Color register write channel of the text console writer.
interface tcw_cfg_if
    import tcw_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/text_console_writer.sv
// Text console writer: character-cell screen held in one synchronous memory.
// A put that scrolls walks the whole screen memory. One item is in work at a time;
// the next input transfer is taken once the result is staged in the output register.
// After reset a clearing pass writes blanks to all COLUMNS*ROWS cells (one a cycle)
// before the first input transfer.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcw_in_if.sink    i_in,
    tcw_cfg_if.sink   i_cfg,
    tcw_out_if.source o_out
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int XW    = AW + CELL_ADDR_W;   // room for any address sum

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    // Screen store: one write and one registered read per cycle.
    t_cell mem [CELLS];

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    t_byte         r_color;
    logic [AW-1:0] r_cnt;          // clearing pass and scroll sweep index

    // Scroll write-back stage, in the cycle after the source read.
    logic          r_sw_valid;
    logic          r_sw_blank;
    logic [AW-1:0] r_sw_dst;

    t_cell         r_rd_data;
    logic          r_rd_ok;
    t_cell         r_res_data;
    logic          r_res_scrolled;

    logic                    r_out_valid;
    logic [CURSOR_POS_W-1:0] r_out_pos;
    t_cell                   r_out_data;
    logic                    r_out_scrolled;

    // Cursor linear index from the current cursor registers.
    logic [XW-1:0] cur_lin;
    assign cur_lin = XW'(r_row) * XW'(COLUMNS) + XW'(r_col);

    logic in_xfer, is_put, is_nl, col_last, row_last, advance, do_scroll;
    assign in_xfer  = i_in.valid && i_in.ready;
    assign is_put   = (i_in.op == OP_PUT);
    assign is_nl    = (i_in.char_code == NEWLINE_CODE);
    assign col_last = (r_col == CW'(COLUMNS - 1));
    assign row_last = (r_row == RW'(ROWS - 1));
    assign advance  = is_nl || col_last;
    assign do_scroll = advance && row_last;

    // Read address for a read item, range check done in the wide domain.
    logic [XW-1:0] rd_ext;
    logic          rd_in_range;
    assign rd_ext      = XW'(i_in.cell_address);
    assign rd_in_range = (rd_ext < XW'(CELLS));

    // Scroll source is one row below the destination.
    logic [XW-1:0] src_ext;
    logic          src_in_range;
    assign src_ext      = XW'(r_cnt) + XW'(COLUMNS);
    assign src_in_range = (src_ext < XW'(CELLS));

    logic cnt_last;
    assign cnt_last = (r_cnt == AW'(CELLS - 1));

    logic out_free;
    assign out_free = !r_out_valid || o_out.ready;

    // Memory port selection: clearing pass, put write, scroll write-back.
    logic          wr_en, rd_en, put_wr;
    logic [AW-1:0] wr_addr, rd_addr;
    t_cell         wr_data;

    assign put_wr = in_xfer && is_put && !is_nl;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cnt;
        wr_data = BLANK_CELL;
        if (r_state == S_CLEAR) begin
            wr_en = 1'b1;
        end else if (put_wr) begin
            wr_en   = 1'b1;
            wr_addr = cur_lin[AW-1:0];
            wr_data = {r_color, i_in.char_code};
        end else if (r_sw_valid) begin
            wr_en   = 1'b1;
            wr_addr = r_sw_dst;
            wr_data = r_sw_blank ? {r_color, SPACE_CODE} : r_rd_data;
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = src_ext[AW-1:0];
        if (in_xfer && !is_put && rd_in_range) begin
            rd_en   = 1'b1;
            rd_addr = rd_ext[AW-1:0];
        end else if (r_state == S_SCROLL && src_in_range) begin
            rd_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Next state and cursor.
    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_row   = r_row;
        case (r_state)
            S_CLEAR: begin
                if (cnt_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_xfer) begin
                    if (!is_put) begin
                        n_state = S_READ;
                    end else begin
                        n_col   = advance ? '0 : r_col + 1'b1;
                        n_row   = (advance && !row_last) ? r_row + 1'b1 : r_row;
                        n_state = do_scroll ? S_SCROLL : S_FINISH;
                    end
                end
            end
            S_READ: begin
                n_state = S_FINISH;
            end
            S_SCROLL: begin
                if (cnt_last) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_col       <= '0;
            r_row       <= '0;
            r_color     <= RESET_COLOR;
            r_cnt       <= '0;
            r_sw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            if (i_cfg.valid) begin
                r_color <= i_cfg.data;
            end
            // Advance the sweep index in clear and scroll; reset it otherwise.
            if (r_state == S_CLEAR || r_state == S_SCROLL) begin
                r_cnt <= cnt_last ? '0 : r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            r_sw_valid <= (r_state == S_SCROLL);
            if (r_state == S_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_sw_dst   <= r_cnt;
        r_sw_blank <= !src_in_range;
        if (in_xfer) begin
            r_rd_ok        <= !is_put && rd_in_range;
            r_res_data     <= '0;
            r_res_scrolled <= is_put && do_scroll;
        end
        if (r_state == S_READ && r_rd_ok) begin
            r_res_data <= r_rd_data;
        end
        if (r_state == S_FINISH && out_free) begin
            r_out_pos      <= cur_lin[CURSOR_POS_W-1:0];
            r_out_data     <= r_res_data;
            r_out_scrolled <= r_res_scrolled;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.cursor_pos = r_out_pos;
    assign o_out.cell_data  = r_out_data;
    assign o_out.scrolled   = r_out_scrolled;

    // A put write never collides with a scroll write-back.
    a_no_wr_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(put_wr && r_sw_valid))
        else $error("put write overlaps scroll write-back");

    // The cursor row never passes the last row.
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= RW'(ROWS - 1))
        else $error("cursor row out of range");

    // A read item goes on to fetch its cell in the next cycle.
    a_read_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !is_put) |=> (r_state == S_READ))
        else $error("read item did not enter fetch");

    // A result appears only from the finish step.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FINISH))
        else $error("result staged outside finish");

endmodule
